// ===== hdl/scy_pkg.sv =====
// Shared types, sizes and helper functions of the scytale transposition block.
// No dependencies; compiled first.
package scy_pkg;

  localparam int MAX_ROWS   = 8;
  localparam int MAX_COLS   = 8;
  localparam int CELLS      = MAX_ROWS * MAX_COLS;
  localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ADDR_W     = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int DIM_W      = 4;
  localparam int CNT_W      = 7;
  localparam int CHAR_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS = 2'd0,
    REG_COLS = 2'd1,
    REG_MODE = 2'd2
  } cfg_reg_t;

  // One complete block waiting in a bank
  typedef struct packed {
    logic             bank;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic             decrypt;
    logic [CNT_W-1:0] total;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W:0]   addr;
    logic [CHAR_W-1:0] data;
  } wr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } done_t;

  // zero reads as one, large values saturate
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v, input int unsigned lim);
    if (v == '0) return DIM_W'(1);
    if (32'(v) > lim) return DIM_W'(lim);
    return v;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(int'(row) * MAX_COLS + int'(col));
  endfunction

endpackage

// ===== hdl/scy_if.sv =====
// Valid/ready channel interfaces for the byte input and the transposed output.
// Depends on scy_pkg.
interface scy_in_if;
  import scy_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface scy_out_if;
  import scy_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              block_last;
  modport source (output valid, output char_out, output block_last, input ready);
  modport sink (input valid, input char_out, input block_last, output ready);
endinterface

// ===== hdl/scy_front.sv =====
// Front end: configuration registers, input acceptance and grid write addressing.
// Fills one of two banks and hands finished blocks on as jobs. Depends on scy_pkg, scy_if.
module scy_front import scy_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  scy_in_if.sink                in_ch,
  output wr_t                   wr_o,
  output job_t                  job_o,
  output logic                  push_o,
  input  logic                  q_full_i,
  input  done_t                 done_i
);

  logic [DIM_W-1:0]   rows_cfg_r, rows_cfg_nxt;
  logic [DIM_W-1:0]   cols_cfg_r, cols_cfg_nxt;
  logic               mode_r, mode_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic               bank_r, bank_nxt;
  logic [1:0]         busy_r, busy_nxt;

  logic [DIM_W-1:0]   eff_rows, eff_cols;
  logic [2*DIM_W-1:0] prod;
  logic [CNT_W-1:0]   total;
  logic               accept, last_in, row_last, col_last, cfg_hit;

  assign eff_rows = eff_dim(rows_cfg_r, MAX_ROWS);
  assign eff_cols = eff_dim(cols_cfg_r, MAX_COLS);
  assign prod     = eff_rows * eff_cols;
  assign total    = prod[CNT_W-1:0];

  assign in_ch.ready = !busy_r[bank_r] && !q_full_i;
  assign accept      = in_ch.valid && in_ch.ready;
  assign last_in     = (fill_r == total - CNT_W'(1));
  assign row_last    = (DIM_W'(row_r) == eff_rows - DIM_W'(1));
  assign col_last    = (DIM_W'(col_r) == eff_cols - DIM_W'(1));

  assign wr_o.en   = accept;
  assign wr_o.addr = {bank_r, cell_addr(row_r, col_r)};
  assign wr_o.data = in_ch.char_in;

  assign push_o        = accept && last_in;
  assign job_o.bank    = bank_r;
  assign job_o.rows    = eff_rows;
  assign job_o.cols    = eff_cols;
  assign job_o.decrypt = mode_r;
  assign job_o.total   = total;

  always_comb begin
    rows_cfg_nxt = rows_cfg_r;
    cols_cfg_nxt = cols_cfg_r;
    mode_nxt     = mode_r;
    cfg_hit      = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS: begin
          rows_cfg_nxt = cfg_data;
          cfg_hit      = 1'b1;
        end
        REG_COLS: begin
          cols_cfg_nxt = cfg_data;
          cfg_hit      = 1'b1;
        end
        REG_MODE: begin
          mode_nxt = cfg_data[0];
          cfg_hit  = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    fill_nxt = fill_r;
    bank_nxt = bank_r;
    busy_nxt = busy_r;
    if (done_i.valid) busy_nxt[done_i.bank] = 1'b0;
    if (cfg_hit) begin
      // a register write drops the partial block
      row_nxt  = '0;
      col_nxt  = '0;
      fill_nxt = '0;
    end else if (accept) begin
      if (last_in) begin
        row_nxt          = '0;
        col_nxt          = '0;
        fill_nxt         = '0;
        bank_nxt         = !bank_r;
        busy_nxt[bank_r] = 1'b1;
      end else begin
        fill_nxt = fill_r + CNT_W'(1);
        if (mode_r) begin
          // decrypt fills column by column
          if (row_last) begin
            row_nxt = '0;
            col_nxt = col_r + COL_W'(1);
          end else begin
            row_nxt = row_r + ROW_W'(1);
          end
        end else begin
          if (col_last) begin
            col_nxt = '0;
            row_nxt = row_r + ROW_W'(1);
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= DIM_W'(1);
      cols_cfg_r <= DIM_W'(1);
      mode_r     <= 1'b0;
      row_r      <= '0;
      col_r      <= '0;
      fill_r     <= '0;
      bank_r     <= 1'b0;
      busy_r     <= '0;
    end else begin
      rows_cfg_r <= rows_cfg_nxt;
      cols_cfg_r <= cols_cfg_nxt;
      mode_r     <= mode_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      fill_r     <= fill_nxt;
      bank_r     <= bank_nxt;
      busy_r     <= busy_nxt;
    end
  end

endmodule

// ===== hdl/scy_queue.sv =====
// Two-entry job queue between the front end and the read-out engine.
// Depends on scy_pkg.
module scy_queue import scy_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic full_o,
  output logic empty_o
);

  job_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full_o  = (count_r == 2'd2);
  assign empty_o = (count_r == 2'd0);
  assign job_o   = slot_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 2'd1;
    else if (do_pop && !do_push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= job_i;
  end

endmodule

// ===== hdl/scy_back.sv =====
// Read-out engine: the two-bank grid memory and the transposed read sequence.
// Registered read, then an output register toward the sink. Depends on scy_pkg, scy_if.
module scy_back import scy_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  wr_t      wr_i,
  input  job_t     q_job_i,
  input  logic     q_empty_i,
  output logic     q_pop_o,
  output done_t    done_o,
  scy_out_if.source out_ch
);

  logic [CHAR_W-1:0] grid_mem [2*CELLS];

  logic              active_r, active_nxt;
  job_t              job_r;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic              s1_v_r, s1_v_nxt;
  logic              s1_last_r;
  logic [CHAR_W-1:0] rd_data_r;
  logic              out_v_r, out_v_nxt;
  logic [CHAR_W-1:0] out_data_r;
  logic              out_last_r;

  logic out_free, s1_move, issue, is_last, row_last, col_last;

  assign out_free = !out_v_r || out_ch.ready;
  assign s1_move  = s1_v_r && out_free;
  assign issue    = active_r && (!s1_v_r || out_free);
  assign is_last  = (cnt_r == job_r.total - CNT_W'(1));
  assign row_last = (DIM_W'(row_r) == job_r.rows - DIM_W'(1));
  assign col_last = (DIM_W'(col_r) == job_r.cols - DIM_W'(1));

  assign q_pop_o      = !active_r && !q_empty_i;
  assign done_o.valid = issue && is_last;
  assign done_o.bank  = job_r.bank;

  assign out_ch.valid      = out_v_r;
  assign out_ch.char_out   = out_data_r;
  assign out_ch.block_last = out_last_r;

  always_ff @(posedge clk) begin
    if (wr_i.en) grid_mem[wr_i.addr] <= wr_i.data;
  end

  always_ff @(posedge clk) begin
    if (issue) rd_data_r <= grid_mem[{job_r.bank, cell_addr(row_r, col_r)}];
  end

  always_comb begin
    active_nxt = active_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    cnt_nxt    = cnt_r;
    if (q_pop_o) begin
      active_nxt = 1'b1;
      row_nxt    = '0;
      col_nxt    = '0;
      cnt_nxt    = '0;
    end else if (issue) begin
      if (is_last) begin
        active_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (job_r.decrypt) begin
          // decrypt reads row by row
          if (col_last) begin
            col_nxt = '0;
            row_nxt = row_r + ROW_W'(1);
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
        end else begin
          if (row_last) begin
            row_nxt = '0;
            col_nxt = col_r + COL_W'(1);
          end else begin
            row_nxt = row_r + ROW_W'(1);
          end
        end
      end
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (issue) s1_v_nxt = 1'b1;
    else if (s1_move) s1_v_nxt = 1'b0;
    out_v_nxt = out_v_r;
    if (s1_move) out_v_nxt = 1'b1;
    else if (out_ch.ready) out_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      row_r    <= '0;
      col_r    <= '0;
      cnt_r    <= '0;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      cnt_r    <= cnt_nxt;
      s1_v_r   <= s1_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop_o) job_r <= q_job_i;
    if (issue) s1_last_r <= is_last;
    if (s1_move) begin
      out_data_r <= rd_data_r;
      out_last_r <= s1_last_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (cnt_r < job_r.total))
    else $error("read counter ran past the block size");

  a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && is_last) |=> !active_r)
    else $error("read engine still active after the last read");

  a_pop_starts_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop_o |=> (active_r && cnt_r == '0))
    else $error("job pop did not start a fresh read sequence");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !out_free) |=> (s1_v_r && $stable(rd_data_r)))
    else $error("read data stage lost its byte under backpressure");
`endif

endmodule

// ===== hdl/scytale_transposition.sv =====
// Scytale transposition block. Bytes are written into a rows x cols grid (row by row when
// encrypting, column by column when decrypting) and, once the block is full, read out in the
// other order with block_last on the final byte. The grid memory has two 64-byte banks: the
// front end fills one bank at one byte per cycle while not stalled, and the read-out engine
// drains the other at one byte per cycle while the sink is ready, so a stream of blocks runs at
// up to one byte per cycle on each side. Input stalls only when both banks hold blocks not yet
// fully read. A write to the rows, cols or mode register restarts the block being filled.
// Depends on scy_pkg, scy_if, scy_front, scy_queue, scy_back.
module scytale_transposition import scy_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  scy_in_if.sink                in_ch,
  scy_out_if.source             out_ch
);

  wr_t   wr;
  job_t  push_job, pop_job;
  logic  push, pop, q_full, q_empty;
  done_t done;

  scy_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .wr_o      (wr),
    .job_o     (push_job),
    .push_o    (push),
    .q_full_i  (q_full),
    .done_i    (done)
  );

  scy_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (pop_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  scy_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_i      (wr),
    .q_job_i   (pop_job),
    .q_empty_i (q_empty),
    .q_pop_o   (pop),
    .done_o    (done),
    .out_ch    (out_ch)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for scytale_transposition: directed grid cases, then random blocks.
// Uses scy_pkg and the scy_in_if / scy_out_if channel interfaces from the RTL.
// Expected bytes come from an in-bench model of the transposition grid.
module testbench;
  import scy_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS  = 250;
  localparam int unsigned REPORT_MAX    = 10;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } transposed_byte_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  scy_in_if  in_ch();
  scy_out_if out_ch();

  scytale_transposition dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // grid model state
  logic [CHAR_W-1:0]     grid_copy [CELLS];
  logic [CNT_W-1:0]      fill_cnt    = '0;
  logic [CFG_DATA_W-1:0] rows_reg    = 4'd1;
  logic [CFG_DATA_W-1:0] cols_reg    = 4'd1;
  logic                  decrypt_reg = 1'b0;

  transposed_byte_t pending_bytes [$];
  int unsigned      mismatch_count = 0;
  bit               in_quiet       = 1'b0;
  bit               out_quiet      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("testbench: FAIL");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) $display("%0t mismatch: %s", $time, msg);
  endtask

  // zero counts as one, saturate at the grid limits, cap the block at CELLS
  function automatic void grid_dims(output int unsigned rows, output int unsigned cols);
    rows = (rows_reg == 0) ? 1 : rows_reg;
    if (rows > MAX_ROWS) rows = MAX_ROWS;
    cols = (cols_reg == 0) ? 1 : cols_reg;
    if (cols > MAX_COLS) cols = MAX_COLS;
    if (cols > CELLS / rows) cols = CELLS / rows;
  endfunction

  function automatic void grid_accept(input logic [CHAR_W-1:0] ch);
    int unsigned rows, cols, total, k, r, c;
    transposed_byte_t t;
    grid_dims(rows, cols);
    total = rows * cols;
    if (fill_cnt >= total) fill_cnt = '0;
    k = fill_cnt;
    if (decrypt_reg) begin
      c = k / rows;
      r = k % rows;
    end else begin
      r = k / cols;
      c = k % cols;
    end
    grid_copy[(r * MAX_COLS + c) % CELLS] = ch;
    fill_cnt = CNT_W'(k + 1);
    if (fill_cnt < total) return;
    fill_cnt = '0;
    // read out in the opposite order
    for (int unsigned i = 0; i < total; i++) begin
      if (decrypt_reg) begin
        r = i / cols;
        c = i % cols;
      end else begin
        c = i / rows;
        r = i % rows;
      end
      t.ch   = grid_copy[(r * MAX_COLS + c) % CELLS];
      t.last = (i + 1 == total);
      pending_bytes.push_back(t);
    end
  endfunction

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    // a partial block may still be in flight into the grid
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ROWS: rows_reg = data;
      REG_COLS: cols_reg = data;
      REG_MODE: decrypt_reg = data[0];
      default: return;
    endcase
    fill_cnt = '0;
  endtask

  task automatic send_byte(input logic [CHAR_W-1:0] ch);
    int unsigned gap;
    if ($urandom_range(31) == 0) in_quiet = !in_quiet;
    gap = in_quiet ? 0 : $urandom_range(15);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.char_in <= ch;
    do @(posedge clk); while (!in_ch.ready);
    grid_accept(ch);
  endtask

  // result side: random stall before each transaction
  initial begin : result_sink
    int unsigned stall;
    forever begin
      if ($urandom_range(63) == 0) out_quiet = !out_quiet;
      stall = out_quiet ? 0 : $urandom_range(15);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  always @(posedge clk) begin : result_check
    transposed_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        note_mismatch($sformatf("unexpected byte %02h last %0b",
                                out_ch.char_out, out_ch.block_last));
      end else begin
        want = pending_bytes.pop_front();
        if (want.ch !== out_ch.char_out || want.last !== out_ch.block_last)
          note_mismatch($sformatf("char_out exp %02h got %02h, block_last exp %0b got %0b",
                                  want.ch, out_ch.char_out, want.last, out_ch.block_last));
      end
    end
  end

  task automatic test_reset_defaults();
    // 1x1 encrypt: every byte is a block of its own
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_zero_dims();
    write_reg(REG_ROWS, 4'd0);
    write_reg(REG_COLS, 4'd0);
    send_byte(8'h55);
  endtask

  task automatic test_encrypt_grid();
    write_reg(REG_ROWS, 4'd2);
    write_reg(REG_COLS, 4'd3);
    write_reg(REG_MODE, 4'd0);
    for (int i = 0; i < 6; i++) send_byte(8'hA0 + 8'(i));
  endtask

  task automatic test_decrypt_spare_reg();
    // only bit 0 of the mode data counts
    write_reg(REG_MODE, 4'hF);
    write_reg(REG_ROWS, 4'd3);
    write_reg(REG_COLS, 4'd2);
    send_byte(8'h11);
    send_byte(8'h22);
    // unmapped index must not restart the block
    write_reg(REG_SPARE, 4'h7);
    for (int i = 0; i < 4; i++) send_byte(8'h33 + 8'(i * 17));
  endtask

  task automatic test_abandon_saturate();
    send_byte(8'hDE);
    send_byte(8'hAD);
    send_byte(8'hBE);
    // partial block is dropped; rows saturate to 8, cols 0 reads as 1, mode back to encrypt
    write_reg(REG_ROWS, 4'd9);
    write_reg(REG_COLS, 4'd0);
    write_reg(REG_MODE, 4'hE);
    for (int i = 0; i < 8; i++) send_byte(8'h01 << i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    if ($urandom_range(7) == 0) return CFG_DATA_W'($urandom_range(15));
    return CFG_DATA_W'($urandom_range(1, 4));
  endfunction

  // reg_mask bits: 0 rows, 1 cols, 2 mode, 3 spare index
  task automatic run_phase(input logic [CFG_DATA_W-1:0] rows_d, input logic [CFG_DATA_W-1:0] cols_d,
                           input logic [CFG_DATA_W-1:0] mode_d, input logic [3:0] reg_mask,
                           input int unsigned blocks, inout int unsigned sent);
    int unsigned rows, cols, total, tail;
    if (reg_mask[3]) write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(15)));
    if (reg_mask[0]) write_reg(REG_ROWS, rows_d);
    if (reg_mask[1]) write_reg(REG_COLS, cols_d);
    if (reg_mask[2]) write_reg(REG_MODE, mode_d);
    grid_dims(rows, cols);
    total = rows * cols;
    // sometimes leave a broken block behind
    tail = (total > 1 && $urandom_range(2) == 0) ? $urandom_range(1, total - 1) : 0;
    repeat (blocks * total + tail) send_byte(CHAR_W'($urandom_range(255)));
    sent += blocks * total + tail;
  endtask

  task automatic test_random_blocks();
    int unsigned sent;
    sent = 0;
    run_phase(4'd8, 4'd8, 4'd0, 4'b0111, 1, sent);
    run_phase(4'd12, 4'd15, 4'd3, 4'b0111, 1, sent);
    while (sent < RANDOM_ITEMS)
      run_phase(pick_dim(), pick_dim(), CFG_DATA_W'($urandom_range(15)),
                4'($urandom_range(15)), $urandom_range(1, 3), sent);
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_ROWS;
    cfg_data      <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.char_in <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_zero_dims();
    test_encrypt_grid();
    test_decrypt_spare_reg();
    test_abandon_saturate();
    test_random_blocks();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== scytale_transposition.f =====
hdl/scy_pkg.sv
hdl/scy_if.sv
hdl/scy_front.sv
hdl/scy_queue.sv
hdl/scy_back.sv
hdl/scytale_transposition.sv
tb/testbench.sv
